FILE: hw/rtl/edp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edp_pkg;

  // Width of one string character.
  localparam int unsigned SYM_W  = 8;
  // Width of the distance field on the result channel.
  localparam int unsigned DIST_W = 6;

  // Operation codes carried in bit 0 of in_tuser.
  localparam logic OP_REF   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Control part of a wavefront token travelling along the cell chain.
  typedef struct packed {
    logic             vld;  // token present
    logic             upd;  // token carries a query character that updates the row
    logic             res;  // last item of the query: emit a result at the chain end
    logic             tl;   // truncation seen for this pair so far
    logic [SYM_W-1:0] sym;  // query character
  } tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/edp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One column of the dynamic-programming row: holds one reference character and
// the row entry below it, and updates that entry as a query token passes.
module edp_cell #(
  parameter int unsigned J  = 1,
  parameter int unsigned DW = 6
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          init,
  input  wire                          wr_en,
  input  wire  [DW-1:0]                wr_idx,
  input  wire  [edp_pkg::SYM_W-1:0]    wr_sym,
  input  wire  [DW-1:0]                ref_len,
  input  wire  edp_pkg::tok_t          tok_i,
  input  wire  [DW-1:0]                left_i,
  input  wire  [DW-1:0]                diag_i,
  output edp_pkg::tok_t                tok_o,
  output logic [DW-1:0]                left_o,
  output logic [DW-1:0]                diag_o
);

  logic [edp_pkg::SYM_W-1:0] ref_r;
  logic [DW-1:0]             d_r;
  logic [DW-1:0]             d_nxt;
  logic                      active;
  logic                      cost;
  logic [DW:0]               up1;
  logic [DW:0]               lf1;
  logic [DW:0]               dg;
  logic [DW:0]               m01;
  edp_pkg::tok_t             tok_r;
  logic [DW-1:0]             left_r;
  logic [DW-1:0]             diag_r;

  // Columns beyond the reference length take no part and pass the left value on,
  // so the chain end always sees the entry under the last reference character.
  assign active = (ref_len >= DW'(J));
  assign cost   = (ref_r != tok_i.sym);
  assign up1    = {1'b0, d_r} + (DW+1)'(1);
  assign lf1    = {1'b0, left_i} + (DW+1)'(1);
  assign dg     = {1'b0, diag_i} + (DW+1)'(cost);
  assign m01    = (up1 < lf1) ? up1 : lf1;
  assign d_nxt  = (m01 < dg) ? m01[DW-1:0] : dg[DW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == DW'(J - 1))) begin
      ref_r <= wr_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      d_r <= DW'(J);
    end else if (tok_i.vld && tok_i.upd && active) begin
      d_r <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_i;
    end
  end

  always_ff @(posedge clk) begin
    diag_r <= d_r;
    if (!active) begin
      left_r <= left_i;
    end else if (tok_i.upd) begin
      left_r <= d_nxt;
    end else begin
      left_r <= d_r;
    end
  end

  assign tok_o  = tok_r;
  assign left_o = left_r;
  assign diag_o = diag_r;

endmodule

`default_nettype wire

FILE: hw/rtl/edit_distance_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Word contents                                   Sideband
// -------  ---  ----------------------------------------------  --------------------------
// in_      in   tdata[7:0] symbol                               tuser[0] op, tuser[1] empty_req,
//                                                               tlast last
// out_     out  tdata[5:0] distance, tdata[7:6] zero            tuser[0] too_long
//
// Each query character enters the chain as a token and moves one cell per cycle,
// so query words are taken back to back; a result is registered at the output after
// the last query word has passed the launch register and every cell of the chain.
// A reference word, and the first word of a new query, wait until the chain has
// drained; a new query also waits for the result register.
// Reset is synchronous and active low; it clears all control state but leaves the
// stored reference characters and row entries undefined until written.
// A stalled result holds in the output register while further words of the
// reference or the current query are still accepted.
module edit_distance_engine #(
  parameter int unsigned MAX_LEN = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] symbol
  input  wire  [1:0] in_tuser,   // [0] op, [1] empty_req
  input  wire        in_tlast,
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [5:0] distance, [7:6] zero
  output logic [0:0] out_tuser   // [0] too_long
);

  localparam int unsigned DW = $clog2(MAX_LEN + 1);
  localparam int unsigned CW = $clog2(MAX_LEN + 3);

  // Reference and query bookkeeping.
  logic [DW-1:0] len_r;
  logic          load_ref_r;
  logic          ref_ovf_r;
  logic          q_act_r;
  logic [DW-1:0] qc_r;
  logic          ovf_seen_r;
  logic [CW-1:0] cnt_r;

  // Token launched into the first cell, with the new and old column-zero entries.
  edp_pkg::tok_t tok0_r;
  logic [DW-1:0] left0_r;
  logic [DW-1:0] diag0_r;

  logic                       out_valid_r;
  logic [edp_pkg::DIST_W-1:0] out_dist_r;
  logic                       out_tl_r;

  logic                      is_query;
  logic                      empty_req;
  logic [edp_pkg::SYM_W-1:0] sym;
  logic                      accept;
  logic                      chain_idle;
  logic                      start;

  // Reference path.
  logic [DW-1:0] len_eff;
  logic          ovf_eff;
  logic          wr_en;

  // Query path.
  logic [DW-1:0] qc_eff;
  logic          upd;
  logic          q_ovf;

  edp_pkg::tok_t tok_c  [0:MAX_LEN];
  logic [DW-1:0] left_c [0:MAX_LEN];
  logic [DW-1:0] diag_c [0:MAX_LEN];

  assign is_query   = (in_tuser[0] == edp_pkg::OP_QUERY);
  assign empty_req  = in_tuser[1];
  assign sym        = in_tdata;
  assign chain_idle = (cnt_r == '0);
  assign start      = is_query && !q_act_r;

  // A query in progress takes its next character at once; anything that rebuilds
  // the row or changes the reference waits for the chain to empty.
  always_comb begin
    if (!is_query) begin
      in_tready = chain_idle;
    end else if (q_act_r) begin
      in_tready = 1'b1;
    end else begin
      in_tready = chain_idle && !out_valid_r;
    end
  end

  assign accept = in_tvalid && in_tready;

  // A reference word after a finished load begins a fresh reference.
  assign len_eff = load_ref_r ? len_r : '0;
  assign ovf_eff = load_ref_r ? ref_ovf_r : 1'b0;
  assign wr_en   = accept && !is_query && !empty_req && (len_eff < DW'(MAX_LEN));

  // The first query word restarts the count and inherits the reference overflow.
  assign qc_eff = start ? '0 : qc_r;
  assign upd    = !empty_req && (qc_eff < DW'(MAX_LEN));
  assign q_ovf  = (start ? ref_ovf_r : ovf_seen_r) || (!empty_req && !upd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      load_ref_r <= 1'b1;
      ref_ovf_r  <= 1'b0;
      q_act_r    <= 1'b0;
      qc_r       <= '0;
      ovf_seen_r <= 1'b0;
    end else if (accept) begin
      if (!is_query) begin
        q_act_r    <= 1'b0;
        load_ref_r <= !in_tlast;
        ref_ovf_r  <= ovf_eff || (!empty_req && !wr_en);
        len_r      <= wr_en ? len_eff + DW'(1) : len_eff;
      end else begin
        load_ref_r <= 1'b0;
        q_act_r    <= !in_tlast;
        qc_r       <= upd ? qc_eff + DW'(1) : qc_eff;
        ovf_seen_r <= q_ovf;
      end
    end
  end

  // Counts down the cycles until the last launched token has left the chain,
  // including the cycle in which it sits at the chain end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept && is_query) begin
      cnt_r <= CW'(MAX_LEN + 2);
    end else if (!chain_idle) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r <= '0;
    end else begin
      tok0_r.vld <= accept && is_query;
      tok0_r.upd <= upd;
      tok0_r.res <= in_tlast;
      tok0_r.tl  <= q_ovf;
      tok0_r.sym <= sym;
    end
  end

  always_ff @(posedge clk) begin
    left0_r <= upd ? qc_eff + DW'(1) : qc_eff;
    diag0_r <= qc_eff;
  end

  assign tok_c[0]  = tok0_r;
  assign left_c[0] = left0_r;
  assign diag_c[0] = diag0_r;

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    edp_cell #(
      .J  (k),
      .DW (DW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .init    (accept && start),
      .wr_en   (wr_en),
      .wr_idx  (len_eff),
      .wr_sym  (sym),
      .ref_len (len_r),
      .tok_i   (tok_c[k-1]),
      .left_i  (left_c[k-1]),
      .diag_i  (diag_c[k-1]),
      .tok_o   (tok_c[k]),
      .left_o  (left_c[k]),
      .diag_o  (diag_c[k])
    );
  end

  // The last token of a query brings the entry under the final reference
  // character to the chain end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_c[MAX_LEN].vld && tok_c[MAX_LEN].res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_c[MAX_LEN].vld && tok_c[MAX_LEN].res) begin
      out_dist_r <= edp_pkg::DIST_W'(left_c[MAX_LEN]);
      out_tl_r   <= tok_c[MAX_LEN].tl;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {(8 - edp_pkg::DIST_W)'(0), out_dist_r};
  assign out_tuser[0] = out_tl_r;

  // A result leaving the chain always finds the output register free.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_c[MAX_LEN].vld && tok_c[MAX_LEN].res) |-> !out_valid_r)
    else $error("result reached the chain end while the output register was full");

  // Neither the launch register nor the chain end holds a token once the drain count has expired.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    chain_idle |-> (!tok0_r.vld && !tok_c[MAX_LEN].vld))
    else $error("token in flight with the drain count at zero");

  // The row is only rebuilt on an empty chain.
  a_init_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && start) |-> (chain_idle && !out_valid_r))
    else $error("query started with tokens or a result still pending");

  // Reference writes never land while tokens still read the reference.
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> chain_idle)
    else $error("reference written while the chain was busy");

  // Counts stay within the row.
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= DW'(MAX_LEN)) && (qc_r <= DW'(MAX_LEN)))
    else $error("reference length or query count beyond the row");

endmodule

`default_nettype wire
